FILE: rtl/kgr_pkg.sv
// kgr_pkg: shared types and constants of the k-group reverser.
// Holds the group descriptor and result beat structs; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kgr_pkg;

    localparam int VAL_W = 32;
    localparam int CFG_W = 5;
    // widest group count for MAX_GROUP up to 64
    localparam int CNT_W = 7;
    localparam logic [CFG_W-1:0] GS_RESET = 5'd1;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             reverse;
        logic             list_end;
    } t_desc;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    run_last;
        logic                    list_done;
    } t_res;

endpackage
`default_nettype wire

FILE: rtl/kgr_gbuf.sv
// kgr_gbuf: ping-pong group store, two banks of MAX_GROUP values.
// One write port, one registered read port. Uses kgr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kgr_gbuf #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_wr_en,
    input  wire logic [AW-1:0]                   i_wr_addr,
    input  wire logic signed [kgr_pkg::VAL_W-1:0] i_wr_data,
    input  wire logic                            i_rd_en,
    input  wire logic [AW-1:0]                   i_rd_addr,
    output      logic signed [kgr_pkg::VAL_W-1:0] o_rd_data
);
    import kgr_pkg::*;

    logic signed [VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/kgr_front.sv
// kgr_front: accepts values, fills the open bank, closes groups into descriptors.
// Holds the group_size register. Uses kgr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kgr_front #(
    parameter int MAX_GROUP = 16,
    parameter int CW        = 5,
    parameter int AW        = 5
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [kgr_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                             i_push,
    input  wire logic signed [kgr_pkg::VAL_W-1:0] i_value,
    input  wire logic                             i_list_end,
    input  wire logic                             i_full,
    output      logic                             o_wr_en,
    output      logic [AW-1:0]                    o_wr_addr,
    output      logic signed [kgr_pkg::VAL_W-1:0] o_wr_data,
    output      logic                             o_desc_push,
    output      kgr_pkg::t_desc                   o_desc
);
    import kgr_pkg::*;

    logic [CFG_W-1:0] r_group_size, n_group_size;
    logic [CW-1:0]    r_fill, n_fill;
    logic             r_wbank, n_wbank;

    logic [CW-1:0] k;
    logic [CW-1:0] cnt;
    logic [CW:0]   a_sum;
    logic          accept, full_grp, close;

    always_comb begin
        priority if (r_group_size == '0) begin
            k = CW'(1);
        end else if (int'(r_group_size) > MAX_GROUP) begin
            k = CW'(MAX_GROUP);
        end else begin
            k = CW'(r_group_size);
        end
    end

    assign cnt      = r_fill + CW'(1);
    assign accept   = i_push && !i_full;
    assign full_grp = (cnt >= k);
    assign close    = full_grp || i_list_end;
    assign a_sum    = {1'b0, r_fill} + (r_wbank ? (CW+1)'(MAX_GROUP) : '0);

    assign o_wr_en   = accept;
    assign o_wr_addr = a_sum[AW-1:0];
    assign o_wr_data = i_value;

    assign o_desc_push    = accept && close;
    assign o_desc.bank     = r_wbank;
    assign o_desc.count    = CNT_W'(cnt);
    assign o_desc.reverse  = full_grp;
    assign o_desc.list_end = i_list_end;

    always_comb begin
        n_group_size = i_cfg_we ? i_cfg_wdata : r_group_size;
        n_fill       = r_fill;
        n_wbank      = r_wbank;
        if (accept) begin
            if (close) begin
                n_fill  = '0;
                n_wbank = !r_wbank;
            end else begin
                n_fill = cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GS_RESET;
            r_fill       <= '0;
            r_wbank      <= 1'b0;
        end else begin
            r_group_size <= n_group_size;
            r_fill       <= n_fill;
            r_wbank      <= n_wbank;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) < MAX_GROUP)
        else $error("open group fill reached bank depth");

endmodule
`default_nettype wire

FILE: rtl/kgr_dq.sv
// kgr_dq: two-entry descriptor queue between front and back.
// Its occupancy also tracks how many banks are committed. Uses kgr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kgr_dq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire kgr_pkg::t_desc i_desc,
    input  wire logic           i_pop,
    output      logic           o_full,
    output      logic           o_valid,
    output      kgr_pkg::t_desc o_head
);
    import kgr_pkg::*;

    t_desc      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_cnt == 2'd2))
        else $error("descriptor queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_cnt == 2'd0))
        else $error("descriptor queue underflow");

endmodule
`default_nettype wire

FILE: rtl/kgr_back.sv
// kgr_back: drains committed groups from the store, forward or reversed,
// into a two-beat result queue. Uses kgr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kgr_back #(
    parameter int MAX_GROUP = 16,
    parameter int CW        = 5,
    parameter int AW        = 5
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_desc_valid,
    input  wire kgr_pkg::t_desc                   i_desc,
    output      logic                             o_desc_pop,
    output      logic                             o_rd_en,
    output      logic [AW-1:0]                    o_rd_addr,
    input  wire logic signed [kgr_pkg::VAL_W-1:0] i_rd_data,
    input  wire logic                             i_pop,
    output      logic                             o_empty,
    output      kgr_pkg::t_res                    o_res
);
    import kgr_pkg::*;

    logic [CW-1:0] r_idx;
    logic          r_inflight, r_rd_last, r_rd_done;
    t_res          r_q [2];
    logic          r_head;
    logic [1:0]    r_ocnt;

    logic [CW-1:0] cnt, slot;
    logic [CW:0]   a_sum;
    logic [1:0]    occ;
    logic          is_last, pop_fire, issue;
    t_res          in_beat;

    assign cnt      = CW'(i_desc.count);
    assign is_last  = (r_idx == cnt - CW'(1));
    assign slot     = i_desc.reverse ? (cnt - CW'(1) - r_idx) : r_idx;
    assign a_sum    = {1'b0, slot} + (i_desc.bank ? (CW+1)'(MAX_GROUP) : '0);
    assign pop_fire = i_pop && (r_ocnt != 2'd0);
    assign occ      = r_ocnt + {1'b0, r_inflight};
    assign issue    = i_desc_valid && ((occ < 2'd2) || pop_fire);

    assign o_rd_en    = issue;
    assign o_rd_addr  = a_sum[AW-1:0];
    assign o_desc_pop = issue && is_last;

    assign in_beat.value     = i_rd_data;
    assign in_beat.run_last  = r_rd_last;
    assign in_beat.list_done = r_rd_done;

    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_q[r_head];

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_last <= is_last;
            r_rd_done <= is_last && i_desc.list_end;
        end
        if (r_inflight) begin
            r_q[r_head ^ r_ocnt[0]] <= in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_inflight <= 1'b0;
            r_head     <= 1'b0;
            r_ocnt     <= 2'd0;
        end else begin
            r_inflight <= issue;
            if (issue) begin
                r_idx <= is_last ? '0 : r_idx + CW'(1);
            end
            if (pop_fire) begin
                r_head <= !r_head;
            end
            r_ocnt <= r_ocnt + {1'b0, r_inflight} - {1'b0, pop_fire};
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ocnt + {1'b0, r_inflight}) <= 2'd2)
        else $error("result queue plus read in flight exceeds two beats");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_desc_valid |-> (r_idx < cnt))
        else $error("drain index past group count");

endmodule
`default_nettype wire

FILE: rtl/k_group_reverser_top.sv
// k_group_reverser_top: reverses a value stream in groups of group_size.
// Ties front, descriptor queue, group store and back together. Uses kgr_pkg.
//
// Input channel: queue style. A beat (i_value, i_list_end) is taken at a
// rising edge with push high and full low. i_list_end marks a list's last value.
// Result channel: queue style. While empty is low the oldest result beat
// (o_value_out, o_run_last, o_list_done) is shown; pop takes it.
// Config: i_cfg_we writes i_cfg_wdata into group_size; only write when idle.
// A group is written into one bank of a two-bank store; when it closes (full
// or list end) a descriptor is queued and the back end drains it, one beat
// per cycle, reversed for a full group and in order for a partial tail.
// With the back end idle, the first beat of a closed group passes the store's
// read register, then the result queue, and shows from there. Throughput: one
// input and one result beat per cycle sustained;
// the input stalls (full high) only while both banks hold undrained groups.
// When the receiver stalls, the two-beat result queue fills, draining stops,
// and then the front stalls. Reset clears fill count, queues and
// group_size (to 1); the store holds no reset value and needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module k_group_reverser_top #(
    parameter int MAX_GROUP = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [kgr_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                             push,
    output      logic                             full,
    input  wire logic signed [kgr_pkg::VAL_W-1:0] i_value,
    input  wire logic                             i_list_end,
    output      logic                             empty,
    input  wire logic                             pop,
    output      logic signed [kgr_pkg::VAL_W-1:0] o_value_out,
    output      logic                             o_run_last,
    output      logic                             o_list_done
);
    import kgr_pkg::*;

    localparam int CW    = $clog2(MAX_GROUP + 1);
    localparam int DEPTH = 2 * MAX_GROUP;
    localparam int AW    = $clog2(DEPTH);

    logic                    wr_en, rd_en, desc_push, desc_pop, desc_valid;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic signed [VAL_W-1:0] wr_data, rd_data;
    t_desc                   desc_in, desc_head;
    t_res                    res;

    kgr_front #(.MAX_GROUP(MAX_GROUP), .CW(CW), .AW(AW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_value     (i_value),
        .i_list_end  (i_list_end),
        .i_full      (full),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_desc_push (desc_push),
        .o_desc      (desc_in)
    );

    kgr_dq u_dq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (desc_in),
        .i_pop   (desc_pop),
        .o_full  (full),
        .o_valid (desc_valid),
        .o_head  (desc_head)
    );

    kgr_gbuf #(.DEPTH(DEPTH), .AW(AW)) u_gbuf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    kgr_back #(.MAX_GROUP(MAX_GROUP), .CW(CW), .AW(AW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (desc_valid),
        .i_desc       (desc_head),
        .o_desc_pop   (desc_pop),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_res        (res)
    );

    assign o_value_out = res.value;
    assign o_run_last  = res.run_last;
    assign o_list_done = res.list_done;

endmodule
`default_nettype wire
